// ===== rtl/cslp_pkg.sv =====
// Shared constants, types and decode functions for the charger status line parser.
package cslp_pkg;

    localparam int FRAC_DIGITS  = 2;
    localparam int VALUE_BITS   = 16;
    localparam int STATUS_CHARS = 9;
    localparam int READINGS     = 4;
    localparam int TARGET_LEN   = 6;

    function automatic int pow10(input int n);
        int r;
        int i;
        r = 1;
        for (i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    localparam int SCALE   = pow10(FRAC_DIGITS);
    localparam int ACC_W   = VALUE_BITS - 1;
    localparam int ACCX_W  = ACC_W + 4;
    localparam int FRAC_W  = $clog2(SCALE + 1);
    localparam int FRACX_W = FRAC_W + 4;
    localparam int FCNT_W  = $clog2(FRAC_DIGITS + 2);
    localparam int MAG_W   = ACC_W + FRAC_W + 1;
    localparam int CNT_W   = $clog2(STATUS_CHARS);
    localparam int PH_W    = 4;
    localparam int SLOT_W  = $clog2(READINGS);

    localparam logic [ACC_W-1:0] SAT_MAX = '1;

    // framing
    localparam logic [1:0] FR_WAIT_LF = 2'd0;
    localparam logic [1:0] FR_SYNC    = 2'd1;
    localparam logic [1:0] FR_READ    = 2'd2;

    // step kinds
    localparam logic [1:0] K_WS  = 2'd0;
    localparam logic [1:0] K_LIT = 2'd1;
    localparam logic [1:0] K_NUM = 2'd2;

    // field phases
    localparam logic [PH_W-1:0] PH_STATUS  = 4'd0;
    localparam logic [PH_W-1:0] PH_FIRST   = 4'd1;
    localparam logic [PH_W-1:0] PH_SOL_NUM = 4'd13;
    localparam logic [PH_W-1:0] PH_DONE    = 4'd14;

    // steps after the status text
    localparam logic [PH_W-1:0] ST_PAD_PS  = 4'd0;
    localparam logic [PH_W-1:0] ST_LIT_PS  = 4'd1;
    localparam logic [PH_W-1:0] ST_NUM_PS  = 4'd2;
    localparam logic [PH_W-1:0] ST_LIT_V1  = 4'd3;
    localparam logic [PH_W-1:0] ST_PAD_BAT = 4'd4;
    localparam logic [PH_W-1:0] ST_LIT_BAT = 4'd5;
    localparam logic [PH_W-1:0] ST_NUM_BAT = 4'd6;
    localparam logic [PH_W-1:0] ST_LIT_V2  = 4'd7;
    localparam logic [PH_W-1:0] ST_NUM_CUR = 4'd8;
    localparam logic [PH_W-1:0] ST_LIT_A   = 4'd9;
    localparam logic [PH_W-1:0] ST_PAD_SOL = 4'd10;
    localparam logic [PH_W-1:0] ST_LIT_SOL = 4'd11;
    localparam logic [PH_W-1:0] ST_NUM_SOL = 4'd12;

    // reading slots
    localparam logic [SLOT_W-1:0] SLOT_PS  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_BAT = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_CUR = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_SOL = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic sign;
        logic neg;
        logic digit;
        logic point;
    } nflags_t;

    typedef struct packed {
        logic [63:0] head;
        logic [7:0]  tail;
        value_t      supply;
        value_t      battery;
        value_t      current;
        value_t      solar;
        logic        ok;
        logic        changed;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] target_char(input logic [CNT_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = "T";
            4'd1:    r = "a";
            4'd2:    r = "r";
            4'd3:    r = "g";
            4'd4:    r = "e";
            4'd5:    r = "t";
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_kind(input logic [PH_W-1:0] s);
        logic [1:0] k;
        case (s)
            ST_PAD_PS, ST_PAD_BAT, ST_PAD_SOL:             k = K_WS;
            ST_NUM_PS, ST_NUM_BAT, ST_NUM_CUR, ST_NUM_SOL: k = K_NUM;
            default:                                       k = K_LIT;
        endcase
        return k;
    endfunction

    function automatic logic [CNT_W-1:0] step_len(input logic [PH_W-1:0] s);
        logic [CNT_W-1:0] n;
        case (s)
            ST_LIT_PS:              n = 4'd3;
            ST_LIT_BAT, ST_LIT_SOL: n = 4'd4;
            ST_LIT_V2:              n = 4'd2;
            ST_LIT_V1, ST_LIT_A:    n = 4'd1;
            default:                n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] lit_char(input logic [PH_W-1:0] s, input logic [1:0] idx);
        logic [31:0] t;
        logic [7:0]  r;
        case (s)
            ST_LIT_PS:  t = {"PS=", 8'h00};
            ST_LIT_V1:  t = {"V", 24'h0};
            ST_LIT_BAT: t = "Bat=";
            ST_LIT_V2:  t = {"V,", 16'h0};
            ST_LIT_A:   t = {"A", 24'h0};
            ST_LIT_SOL: t = "Sol=";
            default:    t = '0;
        endcase
        case (idx)
            2'd0:    r = t[31:24];
            2'd1:    r = t[23:16];
            2'd2:    r = t[15:8];
            default: r = t[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] step_slot(input logic [PH_W-1:0] s);
        logic [SLOT_W-1:0] r;
        case (s)
            ST_NUM_BAT: r = SLOT_BAT;
            ST_NUM_CUR: r = SLOT_CUR;
            ST_NUM_SOL: r = SLOT_SOL;
            default:    r = SLOT_PS;
        endcase
        return r;
    endfunction

    // integer part, kept fraction digits, sign -> saturated signed fixed point
    function automatic value_t num_value(input logic [ACC_W-1:0]  acc,
                                         input logic [FRAC_W-1:0] fr,
                                         input logic [FCNT_W-1:0] fc,
                                         input logic              neg);
        logic [MAG_W-1:0] f;
        logic [MAG_W-1:0] m;
        logic [ACC_W-1:0] s;
        int               i;
        f = MAG_W'(fr);
        for (i = 0; i < FRAC_DIGITS; i++) begin
            if (i >= int'(fc)) begin
                f = f * MAG_W'(10);
            end
        end
        m = MAG_W'(acc) * MAG_W'(SCALE) + f;
        s = (m > MAG_W'(SAT_MAX)) ? SAT_MAX : m[ACC_W-1:0];
        return neg ? -{1'b0, s} : {1'b0, s};
    endfunction

endpackage

// ===== rtl/charger_status_line_parser_core.sv =====
// Top level of the charger status line parser: framing, field matching and result buffer.
//
// Takes one received character per request on the s_ channel and gives one result on the
// m_ channel for every line closed by a carriage return. A line starts at the first
// non-whitespace character after a line feed and must read as nine status characters,
// then PS=, Bat=, current and Sol= numbers; the numbers come out as signed hundredths,
// saturated, with extra fraction digits truncated. Failed lines and lines starting with
// "Target" give line_ok 0 and zero values. Each character passes through an input
// register and is decoded into a two-entry result buffer, so one character is taken
// every cycle while s_ready is high; s_ready drops only while both result entries are full.
module charger_status_line_parser_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [63:0]                          m_status_head,
    output logic [7:0]                           m_status_tail,
    output logic signed [cslp_pkg::VALUE_BITS-1:0] m_supply_hundredths,
    output logic signed [cslp_pkg::VALUE_BITS-1:0] m_battery_hundredths,
    output logic signed [cslp_pkg::VALUE_BITS-1:0] m_current_hundredths,
    output logic signed [cslp_pkg::VALUE_BITS-1:0] m_solar_hundredths,
    output logic                                 m_line_ok,
    output logic                                 m_data_changed
);
    import cslp_pkg::*;

    logic [7:0]        in_byte_reg;
    logic              in_valid_reg;
    logic              proc_go;

    logic [1:0]        frame_reg, frame_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              failed_reg, failed_next;
    logic              ended_reg, ended_next;
    logic              target_reg, target_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    nflags_t           flags_reg, flags_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    logic [7:0]        status_reg [STATUS_CHARS];
    value_t            rd_reg [READINGS];
    logic [7:0]        last_status_reg [STATUS_CHARS];
    value_t            last_rd_reg [READINGS];
    logic              last_valid_reg;

    logic              do_feed;
    logic              do_close;
    logic              lit_go;
    logic              fresh;
    logic [PH_W-1:0]   step;
    logic [ACCX_W-1:0] accx;
    logic [FRACX_W-1:0] fracx;
    logic              stat_we;
    logic [CNT_W-1:0]  stat_idx;
    logic              rd_we;
    logic [SLOT_W-1:0] rd_slot;
    value_t            rd_val;

    value_t            sol_val;
    value_t            rd_out [READINGS];
    logic              line_good;
    logic              changed;
    logic              emit;
    res_t              res_new;

    res_t              out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              pop;

    assign proc_go = in_valid_reg && !skid_valid_reg;
    assign s_ready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_go) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_comb begin
        frame_next  = frame_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        ended_next  = ended_reg;
        target_next = target_reg;
        acc_next    = acc_reg;
        flags_next  = flags_reg;
        frac_next   = frac_reg;
        fcnt_next   = fcnt_reg;
        do_feed     = 1'b0;
        do_close    = 1'b0;
        lit_go      = 1'b0;
        fresh       = 1'b0;
        step        = '0;
        accx        = '0;
        fracx       = '0;
        stat_we     = 1'b0;
        stat_idx    = count_reg;
        rd_we       = 1'b0;
        rd_slot     = SLOT_PS;
        rd_val      = '0;

        if (proc_go) begin
            case (frame_reg)
                FR_WAIT_LF: begin
                    if (in_byte_reg == CH_LF) begin
                        frame_next = FR_SYNC;
                    end
                end
                FR_SYNC: begin
                    if (!is_space(in_byte_reg)) begin
                        frame_next  = FR_READ;
                        phase_next  = PH_STATUS;
                        count_next  = '0;
                        failed_next = 1'b0;
                        ended_next  = 1'b0;
                        target_next = 1'b1;
                        acc_next    = '0;
                        flags_next  = '0;
                        frac_next   = '0;
                        fcnt_next   = '0;
                        do_feed     = 1'b1;
                    end
                end
                FR_READ: begin
                    if (in_byte_reg == CH_CR) begin
                        frame_next = FR_WAIT_LF;
                        do_close   = 1'b1;
                    end else begin
                        do_feed = 1'b1;
                    end
                end
                default: begin
                    frame_next = FR_WAIT_LF;
                end
            endcase
        end

        if (do_feed && !failed_next && !ended_next && phase_next < PH_DONE) begin
            if (in_byte_reg == CH_NUL) begin
                ended_next = 1'b1;
            end else if (phase_next == PH_STATUS) begin
                if (count_next >= CNT_W'(STATUS_CHARS)) begin
                    failed_next = 1'b1;
                end else begin
                    if (count_next < CNT_W'(TARGET_LEN)
                        && in_byte_reg != target_char(count_next)) begin
                        target_next = 1'b0;
                    end
                    stat_we    = 1'b1;
                    stat_idx   = count_next;
                    count_next = count_next + CNT_W'(1);
                    if (count_next == CNT_W'(TARGET_LEN) && target_next) begin
                        failed_next = 1'b1;
                    end
                    if (count_next == CNT_W'(STATUS_CHARS)) begin
                        phase_next = PH_FIRST;
                        count_next = '0;
                        acc_next   = '0;
                        flags_next = '0;
                        frac_next  = '0;
                        fcnt_next  = '0;
                    end
                end
            end else begin
                step = phase_next - PH_W'(1);
                case (step_kind(step))
                    K_WS: begin
                        if (!is_space(in_byte_reg)) begin
                            phase_next = phase_next + PH_W'(1);
                            count_next = '0;
                            lit_go     = 1'b1;
                        end
                    end
                    K_LIT: begin
                        lit_go = 1'b1;
                    end
                    K_NUM: begin
                        fresh = !(flags_next.sign || flags_next.digit || flags_next.point);
                        if (fresh && is_space(in_byte_reg)) begin
                            fresh = 1'b1;
                        end else if (fresh && (in_byte_reg == CH_PLUS
                                               || in_byte_reg == CH_MINUS)) begin
                            flags_next.sign = 1'b1;
                            flags_next.neg  = (in_byte_reg == CH_MINUS);
                        end else if (in_byte_reg >= CH_ZERO && in_byte_reg <= CH_NINE) begin
                            flags_next.digit = 1'b1;
                            if (!flags_next.point) begin
                                accx = ACCX_W'(acc_next) * ACCX_W'(10)
                                       + ACCX_W'(in_byte_reg[3:0]);
                                acc_next = (accx > ACCX_W'(SAT_MAX)) ? SAT_MAX
                                                                      : accx[ACC_W-1:0];
                            end else if (int'(fcnt_next) < FRAC_DIGITS) begin
                                fracx = FRACX_W'(frac_next) * FRACX_W'(10)
                                        + FRACX_W'(in_byte_reg[3:0]);
                                frac_next = fracx[FRAC_W-1:0];
                                fcnt_next = fcnt_next + FCNT_W'(1);
                            end
                        end else if (in_byte_reg == CH_POINT && !flags_next.point) begin
                            flags_next.point = 1'b1;
                        end else if (!flags_next.digit) begin
                            failed_next = 1'b1;
                        end else begin
                            rd_we      = 1'b1;
                            rd_slot    = step_slot(step);
                            rd_val     = num_value(acc_next, frac_next, fcnt_next,
                                                   flags_next.neg);
                            phase_next = phase_next + PH_W'(1);
                            count_next = '0;
                            acc_next   = '0;
                            flags_next = '0;
                            frac_next  = '0;
                            fcnt_next  = '0;
                            lit_go     = (phase_next < PH_DONE);
                        end
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase

                if (lit_go) begin
                    step = phase_next - PH_W'(1);
                    if (count_next < step_len(step)
                        && in_byte_reg == lit_char(step, count_next[1:0])) begin
                        count_next = count_next + CNT_W'(1);
                        if (count_next == step_len(step)) begin
                            count_next = '0;
                            phase_next = phase_next + PH_W'(1);
                            acc_next   = '0;
                            flags_next = '0;
                            frac_next  = '0;
                            fcnt_next  = '0;
                        end
                    end else begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    // close: finish a pending solar number, compare with the last good line
    always_comb begin
        sol_val   = num_value(acc_reg, frac_reg, fcnt_reg, flags_reg.neg);
        line_good = !failed_reg && phase_reg != PH_STATUS
                    && (phase_reg == PH_DONE || (phase_reg == PH_SOL_NUM && flags_reg.digit));
        for (int i = 0; i < READINGS; i++) begin
            rd_out[i] = rd_reg[i];
        end
        if (phase_reg == PH_SOL_NUM) begin
            rd_out[SLOT_SOL] = sol_val;
        end
        changed = !last_valid_reg;
        for (int i = 0; i < STATUS_CHARS; i++) begin
            if (status_reg[i] != last_status_reg[i]) begin
                changed = 1'b1;
            end
        end
        for (int i = 0; i < READINGS; i++) begin
            if (rd_out[i] != last_rd_reg[i]) begin
                changed = 1'b1;
            end
        end
        res_new = '0;
        if (line_good) begin
            for (int i = 0; i < 8; i++) begin
                res_new.head[63-8*i -: 8] = status_reg[i];
            end
            res_new.tail    = status_reg[STATUS_CHARS-1];
            res_new.supply  = rd_out[SLOT_PS];
            res_new.battery = rd_out[SLOT_BAT];
            res_new.current = rd_out[SLOT_CUR];
            res_new.solar   = rd_out[SLOT_SOL];
            res_new.ok      = 1'b1;
            res_new.changed = changed;
        end
    end

    assign emit = do_close;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg      <= FR_WAIT_LF;
            phase_reg      <= PH_STATUS;
            count_reg      <= '0;
            failed_reg     <= 1'b0;
            ended_reg      <= 1'b0;
            target_reg     <= 1'b1;
            acc_reg        <= '0;
            flags_reg      <= '0;
            frac_reg       <= '0;
            fcnt_reg       <= '0;
            last_valid_reg <= 1'b0;
        end else begin
            frame_reg  <= frame_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
            ended_reg  <= ended_next;
            target_reg <= target_next;
            acc_reg    <= acc_next;
            flags_reg  <= flags_next;
            frac_reg   <= frac_next;
            fcnt_reg   <= fcnt_next;
            if (emit && line_good) begin
                last_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stat_we) begin
            status_reg[stat_idx] <= in_byte_reg;
        end
        if (rd_we) begin
            rd_reg[rd_slot] <= rd_val;
        end
        if (emit && line_good) begin
            for (int i = 0; i < STATUS_CHARS; i++) begin
                last_status_reg[i] <= status_reg[i];
            end
            for (int i = 0; i < READINGS; i++) begin
                last_rd_reg[i] <= rd_out[i];
            end
        end
    end

    // two-entry result buffer
    assign pop = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg) begin
            if (emit && !pop) begin
                skid_valid_reg <= 1'b1;
            end else if (!emit && pop) begin
                out_valid_reg <= 1'b0;
            end
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (emit) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= res_new;
            end else begin
                out_reg <= res_new;
            end
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_status_head        = out_reg.head;
    assign m_status_tail        = out_reg.tail;
    assign m_supply_hundredths  = out_reg.supply;
    assign m_battery_hundredths = out_reg.battery;
    assign m_current_hundredths = out_reg.current;
    assign m_solar_hundredths   = out_reg.solar;
    assign m_line_ok            = out_reg.ok;
    assign m_data_changed       = out_reg.changed;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without head entry");

    a_failed_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_line_ok) |-> (!m_data_changed && m_supply_hundredths == '0
            && m_battery_hundredths == '0 && m_current_hundredths == '0
            && m_solar_hundredths == '0))
        else $error("failed line carries values");

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_DONE)
        else $error("field phase past done");

    a_last_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        last_valid_reg |=> last_valid_reg)
        else $error("last line record lost");

endmodule

// ===== bench/charger_status_line_parser_core_tb.sv =====
// Self-checking testbench for the charger status line parser core.
module charger_status_line_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cslp_pkg::*;

    localparam int      NUM_STEPS    = 13;
    localparam int      RANDOM_BYTES = 1100;
    localparam int      TAIL_CYCLES  = 16;
    localparam longint  VAL_MAX      = (longint'(1) << (VALUE_BITS - 1)) - 1;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] MARK_NUL    = "@";
    localparam logic [7:0] MARK_CR     = "|";
    localparam res_t       FAILED_LINE = '0;

    typedef enum logic [1:0] {PAD_STEP, WORD_STEP, NUM_STEP} step_kind_e;

    step_kind_e kind_tab[NUM_STEPS] = '{PAD_STEP, WORD_STEP, NUM_STEP, WORD_STEP, PAD_STEP,
        WORD_STEP, NUM_STEP, WORD_STEP, NUM_STEP, WORD_STEP, PAD_STEP, WORD_STEP, NUM_STEP};
    string word_txt[NUM_STEPS] = '{"", "PS=", "", "V", "", "Bat=", "", "V,", "", "A", "",
        "Sol=", ""};
    int slot_tab[NUM_STEPS] = '{SLOT_PS, SLOT_PS, SLOT_PS, SLOT_PS, SLOT_PS, SLOT_PS,
        SLOT_BAT, SLOT_PS, SLOT_CUR, SLOT_PS, SLOT_PS, SLOT_PS, SLOT_SOL};
    string target_word = "Target";

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_status_head;
    logic [7:0]  m_status_tail;
    value_t      m_supply_hundredths;
    value_t      m_battery_hundredths;
    value_t      m_current_hundredths;
    value_t      m_solar_hundredths;
    logic        m_line_ok;
    logic        m_data_changed;

    // parser state
    logic [1:0]  frame_st;
    int          fld_phase;
    int          fld_pos;
    logic [7:0]  stat_buf[STATUS_CHARS];
    longint      int_part;
    nflags_t     num_fl;
    longint      frac_part;
    int          frac_len;
    int          reading[READINGS];
    bit          bad_line;
    bit          cut_line;
    bit          maybe_target;
    logic [7:0]  prev_stat[STATUS_CHARS];
    int          prev_reading[READINGS];
    bit          prev_seen;

    res_t        pending_reports[$];
    string       dir_text[$];
    bit          dir_typed[$];
    res_t        dir_want[$];
    logic [7:0]  line_bytes[$];
    logic [7:0]  good_line[$];
    int          err_cnt;
    int          live_bytes;
    bit          no_gaps;
    int          ready_hold;

    charger_status_line_parser_core DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status_head        (m_status_head),
        .m_status_tail        (m_status_tail),
        .m_supply_hundredths  (m_supply_hundredths),
        .m_battery_hundredths (m_battery_hundredths),
        .m_current_hundredths (m_current_hundredths),
        .m_solar_hundredths   (m_solar_hundredths),
        .m_line_ok            (m_line_ok),
        .m_data_changed       (m_data_changed)
    );

    function automatic bit is_pad(logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void num_clear_st();
        int_part  = 0;
        num_fl    = '0;
        frac_part = 0;
        frac_len  = 0;
    endfunction

    function automatic bit num_take_ch(logic [7:0] c);
        bit fresh;
        fresh = !(num_fl.sign || num_fl.digit || num_fl.point);
        if (fresh && is_pad(c)) return 1'b1;
        if (fresh && (c == CH_PLUS || c == CH_MINUS)) begin
            num_fl.sign = 1'b1;
            if (c == CH_MINUS) num_fl.neg = 1'b1;
            return 1'b1;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            num_fl.digit = 1'b1;
            if (!num_fl.point) begin
                int_part = int_part * 10 + longint'(c - CH_ZERO);
                if (int_part > VAL_MAX) int_part = VAL_MAX;
            end else if (frac_len < FRAC_DIGITS) begin
                frac_part = frac_part * 10 + longint'(c - CH_ZERO);
                frac_len++;
            end
            return 1'b1;
        end
        if (c == CH_POINT && !num_fl.point) begin
            num_fl.point = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit num_store(int slot);
        longint mag;
        longint fr;
        int     i;
        if (!num_fl.digit) return 1'b0;
        mag = int_part;
        fr  = frac_part;
        for (i = 0; i < FRAC_DIGITS; i++) begin
            mag = mag * 10;
            if (i >= frac_len) fr = fr * 10;
        end
        mag = mag + fr;
        if (mag > VAL_MAX) mag = VAL_MAX;
        reading[slot] = num_fl.neg ? int'(-mag) : int'(mag);
        return 1'b1;
    endfunction

    function automatic void line_begin();
        fld_phase    = int'(PH_STATUS);
        fld_pos      = 0;
        bad_line     = 1'b0;
        cut_line     = 1'b0;
        maybe_target = 1'b1;
        num_clear_st();
    endfunction

    function automatic void feed_ch(logic [7:0] c);
        int s;
        if (bad_line || cut_line || fld_phase >= PH_DONE) return;
        if (c == CH_NUL) begin
            cut_line = 1'b1;
            return;
        end
        if (fld_phase == PH_STATUS) begin
            if (fld_pos >= STATUS_CHARS) begin
                bad_line = 1'b1;
                return;
            end
            if (fld_pos < TARGET_LEN && c != target_word[fld_pos]) maybe_target = 1'b0;
            stat_buf[fld_pos] = c;
            fld_pos++;
            if (fld_pos == TARGET_LEN && maybe_target) bad_line = 1'b1;
            if (fld_pos == STATUS_CHARS) begin
                fld_phase = int'(PH_FIRST);
                fld_pos   = 0;
                num_clear_st();
            end
            return;
        end
        while (1'b1) begin
            s = fld_phase - 1;
            if (s >= NUM_STEPS) return;
            case (kind_tab[s])
                PAD_STEP: begin
                    if (is_pad(c)) return;
                    fld_phase++;
                    fld_pos = 0;
                end
                WORD_STEP: begin
                    if (fld_pos < word_txt[s].len() && c == word_txt[s][fld_pos]) begin
                        fld_pos++;
                        if (fld_pos == word_txt[s].len()) begin
                            fld_pos = 0;
                            fld_phase++;
                            num_clear_st();
                        end
                    end else begin
                        bad_line = 1'b1;
                    end
                    return;
                end
                default: begin
                    if (num_take_ch(c)) return;
                    if (!num_store(slot_tab[s])) begin
                        bad_line = 1'b1;
                        return;
                    end
                    fld_phase++;
                    fld_pos = 0;
                    num_clear_st();
                    if (fld_phase >= PH_DONE) return;
                end
            endcase
        end
    endfunction

    function automatic void close_line(output res_t r);
        bit ok;
        bit chg;
        int i;
        ok = !bad_line && fld_phase != PH_STATUS;
        if (ok && fld_phase == PH_SOL_NUM) begin
            if (num_store(slot_tab[NUM_STEPS-1])) fld_phase = int'(PH_DONE);
        end
        ok = ok && fld_phase == PH_DONE;
        r  = '0;
        if (ok) begin
            chg = !prev_seen;
            for (i = 0; i < STATUS_CHARS; i++) begin
                if (prev_stat[i] != stat_buf[i]) chg = 1'b1;
                prev_stat[i] = stat_buf[i];
            end
            for (i = 0; i < READINGS; i++) begin
                if (prev_reading[i] != reading[i]) chg = 1'b1;
                prev_reading[i] = reading[i];
            end
            prev_seen = 1'b1;
            for (i = 0; i < 8; i++) r.head = {r.head[55:0], stat_buf[i]};
            r.tail    = stat_buf[8];
            r.supply  = value_t'(reading[SLOT_PS]);
            r.battery = value_t'(reading[SLOT_BAT]);
            r.current = value_t'(reading[SLOT_CUR]);
            r.solar   = value_t'(reading[SLOT_SOL]);
            r.ok      = 1'b1;
            r.changed = chg;
        end
    endfunction

    function automatic bit parse_byte(logic [7:0] c, output res_t r);
        r = '0;
        if (frame_st == FR_WAIT_LF) begin
            if (c == CH_LF) frame_st = FR_SYNC;
            return 1'b0;
        end
        if (frame_st == FR_SYNC) begin
            if (!is_pad(c)) begin
                frame_st = FR_READ;
                line_begin();
                feed_ch(c);
            end
            return 1'b0;
        end
        if (c == CH_CR) begin
            frame_st = FR_WAIT_LF;
            close_line(r);
            return 1'b1;
        end
        feed_ch(c);
        return 1'b0;
    endfunction

    function automatic void parser_reset();
        int i;
        frame_st = FR_WAIT_LF;
        line_begin();
        for (i = 0; i < STATUS_CHARS; i++) prev_stat[i] = '0;
        for (i = 0; i < READINGS; i++) prev_reading[i] = 0;
        prev_seen = 1'b0;
    endfunction

    function automatic res_t ok_line(string st, int ps, int bat, int cur, int sol, bit chg);
        res_t w;
        int   i;
        w = '0;
        for (i = 0; i < 8; i++) w.head = {w.head[55:0], st[i]};
        w.tail    = st[8];
        w.supply  = value_t'(ps);
        w.battery = value_t'(bat);
        w.current = value_t'(cur);
        w.solar   = value_t'(sol);
        w.ok      = 1'b1;
        w.changed = chg;
        return w;
    endfunction

    function automatic void add_row(string txt, bit typed, res_t want);
        dir_text.push_back(txt);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endfunction

    function automatic logic [7:0] pad_char(bit allow_cr);
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return allow_cr ? CH_CR : CH_SPACE;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] status_char(bit first);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(33, 126));
            else c = 8'($urandom_range(1, 255));
        end while (c == CH_CR || (first && is_pad(c)));
        return c;
    endfunction

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    function automatic void push_number();
        int sg;
        int k;
        int nd;
        int i;
        bit has_int;
        if ($urandom_range(0, 4) == 0) line_bytes.push_back(pad_char(1'b0));
        sg = $urandom_range(0, 99);
        if (sg < 15) line_bytes.push_back(CH_PLUS);
        else if (sg < 40) line_bytes.push_back(CH_MINUS);
        k = $urandom_range(0, 9);
        has_int = (k != 0);
        if (k == 1) begin
            nd = $urandom_range(5, 20);
            for (i = 0; i < nd; i++) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (k == 2) begin
            push_text($sformatf("%0d", $urandom_range(300, 99999)));
        end else if (k > 2) begin
            push_text($sformatf("%0d", $urandom_range(0, 99)));
        end
        if (!has_int || $urandom_range(0, 1) == 1) begin
            line_bytes.push_back(CH_POINT);
            nd = $urandom_range(has_int ? 0 : 1, 4);
            for (i = 0; i < nd; i++) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void build_good_line();
        line_bytes.delete();
        line_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 2)) line_bytes.push_back(pad_char(1'b1));
        line_bytes.push_back(status_char(1'b1));
        repeat (STATUS_CHARS - 1) line_bytes.push_back(status_char(1'b0));
        repeat ($urandom_range(0, 2)) line_bytes.push_back(pad_char(1'b0));
        push_text("PS=");
        push_number();
        push_text("V");
        repeat ($urandom_range(0, 2)) line_bytes.push_back(pad_char(1'b0));
        push_text("Bat=");
        push_number();
        push_text("V,");
        push_number();
        push_text("A");
        repeat ($urandom_range(0, 2)) line_bytes.push_back(pad_char(1'b0));
        push_text("Sol=");
        push_number();
        if ($urandom_range(0, 3) == 0) begin
            push_text("V");
            repeat ($urandom_range(0, 5)) line_bytes.push_back(status_char(1'b0));
        end
        line_bytes.push_back(CH_CR);
    endfunction

    function automatic void break_line();
        int idx;
        int j;
        int i;
        idx = $urandom_range(1, line_bytes.size() - 2);
        case ($urandom_range(0, 3))
            0: line_bytes[idx] = 8'($urandom_range(0, 255));
            1: begin
                while (line_bytes.size() > idx + 1) void'(line_bytes.pop_back());
                line_bytes.push_back(CH_CR);
            end
            2: line_bytes.insert(idx, CH_NUL);
            default: begin
                j = 1;
                while (is_pad(line_bytes[j])) j++;
                for (i = 0; i < TARGET_LEN; i++) line_bytes[j+i] = target_word[i];
            end
        endcase
    endfunction

    function automatic int sender_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, output bit made, output res_t r);
        int g;
        g = sender_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (frame_st != FR_WAIT_LF || b == CH_LF) live_bytes++;
        made = parse_byte(b, r);
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic send_line_bytes();
        int   i;
        bit   made;
        res_t r;
        for (i = 0; i < line_bytes.size(); i++) begin
            send_byte(line_bytes[i], made, r);
            if (made) begin
                pending_reports.push_back(r);
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int pick;
        m_ready    <= 1'b0;
        ready_hold = 0;
        forever begin
            @(posedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(0, 4);
                end else if (pick < 85) begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(0, 3);
                end else if (pick < 95) begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(50, 200);
                end else begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(10, 60);
                end
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, got head %h ok %b",
                         $time, m_status_head, m_line_ok);
                err_cnt++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status_head", want.head, m_status_head);
                check_field("status_tail", 64'(want.tail), 64'(m_status_tail));
                check_field("supply_hundredths", 64'(want.supply),
                            64'(m_supply_hundredths));
                check_field("battery_hundredths", 64'(want.battery),
                            64'(m_battery_hundredths));
                check_field("current_hundredths", 64'(want.current),
                            64'(m_current_hundredths));
                check_field("solar_hundredths", 64'(want.solar), 64'(m_solar_hundredths));
                check_field("line_ok", 64'(want.ok), 64'(m_line_ok));
                check_field("data_changed", 64'(want.changed), 64'(m_data_changed));
            end
        end
    end

    initial begin
        int         k;
        int         i;
        int         pick;
        logic [7:0] b;
        bit         made;
        res_t       r;
        string      txt;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        err_cnt    = 0;
        live_bytes = 0;
        no_gaps    = 1'b0;
        parser_reset();

        // '@' stands for a NUL and '|' for a carriage return
        add_row("AB|", 1'b0, FAILED_LINE);
        add_row("\n \t\n\013\014ABCDEFGHI PS=99999V Bat=-99999V,0.005A Sol=+1.239V|", 1'b1,
                ok_line("ABCDEFGHI", 32767, -32767, 0, 123, 1'b1));
        add_row("\nABCDEFGHI PS=99999V Bat=-99999V,0.005A Sol=+1.239V|", 1'b1,
                ok_line("ABCDEFGHI", 32767, -32767, 0, 123, 1'b0));
        add_row("\nTarget 12 PS=1V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nTargex 12 PS=1V Bat=1V,1A Sol=1V|", 1'b0, FAILED_LINE);
        add_row("\nABCDEFGHI PS=1V|", 1'b1, FAILED_LINE);
        add_row("\nABCDEFGHI|", 1'b1, FAILED_LINE);
        add_row("\nABC|", 1'b1, FAILED_LINE);
        add_row("\nABCDEFGHI PS=1e3V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nABC@DEFGHI PS=1V Bat=2V,3A Sol=4V|", 1'b1, FAILED_LINE);
        add_row("\n\377\001\t \n\177\200~}  PS=.5V Bat= -2V,7.A Sol=-0@xyz|", 1'b0,
                FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=327.67V Bat=327.68V,-327.689A Sol=32767.99 trailing|", 1'b0,
                FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=1.2.3V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=.V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=1V Bat=- 2V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=+V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nZZZZZZZZZJ PS=1V Bat=1V,1A Sol=1V|", 1'b1, FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=1V Bat=1V,1A Sol=|", 1'b1, FAILED_LINE);
        add_row("\n |", 1'b0, FAILED_LINE);
        add_row("X23456789PS=0V\nBat=00000000000000000000123V,  +0.1A\tSol=5V|", 1'b0,
                FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=1VBat=1V,1A Sol=1V|", 1'b0, FAILED_LINE);
        add_row("\nZZZZZZZZZ PS=1V Bat=1V,1A Sol=1V\n|", 1'b0, FAILED_LINE);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < dir_text.size(); k++) begin
            txt = dir_text[k];
            for (i = 0; i < txt.len(); i++) begin
                b = txt[i];
                if (b == MARK_NUL) b = CH_NUL;
                else if (b == MARK_CR) b = CH_CR;
                send_byte(b, made, r);
                if (made) pending_reports.push_back(
                    (dir_typed[k] && i == txt.len() - 1) ? dir_want[k] : r);
            end
        end

        // hold the sender until the parser has reported every line
        drain_reports();

        live_bytes = 0;
        while (live_bytes < RANDOM_BYTES) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 24) == 0) drain_reports();
            pick = $urandom_range(0, 99);
            if (pick < 12 && good_line.size() != 0) begin
                line_bytes = good_line;
            end else if (pick < 70) begin
                build_good_line();
                good_line = line_bytes;
            end else if (pick < 88) begin
                build_good_line();
                break_line();
            end else begin
                line_bytes.delete();
                repeat ($urandom_range(4, 30)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_line_bytes();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
